// File: rtl/aln_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aln_pkg
// Shared widths, register indexes, reset values and the configuration bundle
// of the audio level normalizer.
// ----------------------------------------------------------------------------
package aln_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int CNT_W      = 4;
    localparam int DIV_CNT_W  = $clog2(SAMPLE_W);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // in tdata: rms_sample, period_elapsed, magnitude
    localparam int S_TDATA_BITS = 2 * SAMPLE_W + 1;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = 2 * SAMPLE_W;

    localparam logic [CFG_ADDR_W-1:0] REG_SILENCE_FLOOR  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIG_GAP        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FAST_RATE      = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MEDIUM_RATE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SLOW_RATE      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_WARMUP_UPDATES = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_LEVEL   = 3'd6;

    localparam logic FUNC_RMS = 1'b0;
    localparam logic FUNC_MAG = 1'b1;

    localparam logic [SAMPLE_W-1:0] RST_SILENCE_FLOOR  = 16'd4588;
    localparam logic [SAMPLE_W-1:0] RST_BIG_GAP        = 16'd6554;
    localparam logic [SAMPLE_W-1:0] RST_FAST_RATE      = 16'd3277;
    localparam logic [SAMPLE_W-1:0] RST_MEDIUM_RATE    = 16'd1638;
    localparam logic [SAMPLE_W-1:0] RST_SLOW_RATE      = 16'd98;
    localparam logic [CNT_W-1:0]    RST_WARMUP_UPDATES = 4'd10;
    localparam logic [SAMPLE_W-1:0] RST_TARGET_LEVEL   = 16'd32768;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL          = 16'd32768;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] silence_floor;
        logic [SAMPLE_W-1:0] big_gap;
        logic [SAMPLE_W-1:0] fast_rate;
        logic [SAMPLE_W-1:0] medium_rate;
        logic [SAMPLE_W-1:0] slow_rate;
        logic [CNT_W-1:0]    warmup_updates;
        logic [SAMPLE_W-1:0] target_level;
    } cfg_t;

endpackage
`default_nettype wire

// File: rtl/aln_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aln_cfg_regs
// Configuration register file written through the index/data channel.
// ----------------------------------------------------------------------------
module aln_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aln_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [aln_pkg::CFG_DATA_W-1:0]   cfg_data,
    output aln_pkg::cfg_t                    cfg
);

    aln_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.silence_floor  <= aln_pkg::RST_SILENCE_FLOOR;
            cfg_reg.big_gap        <= aln_pkg::RST_BIG_GAP;
            cfg_reg.fast_rate      <= aln_pkg::RST_FAST_RATE;
            cfg_reg.medium_rate    <= aln_pkg::RST_MEDIUM_RATE;
            cfg_reg.slow_rate      <= aln_pkg::RST_SLOW_RATE;
            cfg_reg.warmup_updates <= aln_pkg::RST_WARMUP_UPDATES;
            cfg_reg.target_level   <= aln_pkg::RST_TARGET_LEVEL;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                aln_pkg::REG_SILENCE_FLOOR:  cfg_reg.silence_floor  <= cfg_data;
                aln_pkg::REG_BIG_GAP:        cfg_reg.big_gap        <= cfg_data;
                aln_pkg::REG_FAST_RATE:      cfg_reg.fast_rate      <= cfg_data;
                aln_pkg::REG_MEDIUM_RATE:    cfg_reg.medium_rate    <= cfg_data;
                aln_pkg::REG_SLOW_RATE:      cfg_reg.slow_rate      <= cfg_data;
                aln_pkg::REG_WARMUP_UPDATES: begin
                    cfg_reg.warmup_updates <= cfg_data[aln_pkg::CNT_W-1:0];
                end
                aln_pkg::REG_TARGET_LEVEL:   cfg_reg.target_level   <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/aln_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aln_div
// Restoring radix-2 divider, one quotient bit per cycle. The upper half of
// the dividend must be below the divisor, so the quotient fits one sample.
// ----------------------------------------------------------------------------
module aln_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [aln_pkg::PROD_W-1:0]     num,
    input  logic [aln_pkg::SAMPLE_W-1:0]   den,
    output logic                           done,
    output logic [aln_pkg::SAMPLE_W-1:0]   quot
);

    localparam int W = aln_pkg::SAMPLE_W;
    localparam logic [aln_pkg::DIV_CNT_W-1:0] LAST_STEP = '1;

    logic                         busy_reg;
    logic                         done_reg;
    logic [aln_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [W-1:0]                 rem_reg;
    logic [W-1:0]                 shift_reg;
    logic [W-1:0]                 den_reg;
    logic [W:0]                   trial;
    logic [W:0]                   diff;
    logic                         ge;

    // shift_reg feeds dividend bits out the top and takes quotient bits in
    assign trial = {rem_reg, shift_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};
    assign done  = done_reg;
    assign quot  = shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == LAST_STEP);
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                rem_reg   <= num[aln_pkg::PROD_W-1:W];
                shift_reg <= num[W-1:0];
                den_reg   <= den;
            end else if (busy_reg) begin
                rem_reg   <= ge ? diff[W-1:0] : trial[W-1:0];
                shift_reg <= {shift_reg[W-2:0], ge};
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/audio_level_normalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_level_normalizer
// Automatic gain normalizer: tracks the RMS level of the audio and scales
// spectrum magnitudes by target_level / tracked level, Q0.16 unsigned.
// ----------------------------------------------------------------------------
// One word is worked on at a time; s_tready is low while it is in flight, and
// the finished result waits in the output register while the next word comes
// in. An RMS word without period_elapsed goes straight to the emit step; one
// with the period update first passes rate pick and step, then clamp. A
// magnitude word passes the accept, one multiply, one saturation check that
// also loads the bit-serial divider, its 16 steps, one step to take the
// quotient and one to emit. Saturating magnitudes skip the divider. A result
// that finds the output register still held by a low m_tready waits in the
// emit state until that result is taken. Configuration writes are taken at
// any time but belong between words.
// ----------------------------------------------------------------------------
module audio_level_normalizer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rms_sample [15:0], period_elapsed [16], magnitude [32:17], zero [39:33]
    input  logic [aln_pkg::S_TDATA_W-1:0]    s_tdata,
    // func
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // normalized [15:0], level [31:16]
    output logic [aln_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aln_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [aln_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int W = aln_pkg::SAMPLE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE,
        ST_CLAMP,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    aln_pkg::cfg_t cfg;

    state_t                       state_reg;
    logic [W-1:0]                 level_reg;
    logic [W-1:0]                 peak_reg;
    logic [aln_pkg::CNT_W-1:0]    count_reg;
    logic                         up_reg;
    logic [W:0]                   step_reg;
    logic [W-1:0]                 mag_reg;
    logic [aln_pkg::PROD_W-1:0]   prod_reg;
    logic [W-1:0]                 norm_reg;
    logic                         m_valid_reg;
    logic [aln_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [W-1:0] in_rms;
    logic         in_period;
    logic [W-1:0] in_mag;
    logic [W-1:0] rate;
    logic [W-1:0] gap;
    logic         peak_above;
    logic [W-1:0] level_next;
    logic [W-1:0] down_lvl;
    logic         div_start;
    logic         div_done;
    logic [W-1:0] div_quot;
    logic         sat;

    assign in_rms    = s_tdata[W-1:0];
    assign in_period = s_tdata[W];
    assign in_mag    = s_tdata[2*W:W+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    aln_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign sat       = prod_reg[aln_pkg::PROD_W-1:W] >= level_reg;
    assign div_start = (state_reg == ST_CHECK) && !sat;

    aln_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (level_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // rate pick
    assign peak_above = peak_reg > level_reg;
    assign gap        = peak_reg - level_reg;

    always_comb begin
        priority if (peak_reg < cfg.silence_floor) begin
            rate = '0;
        end else if (count_reg < cfg.warmup_updates) begin
            rate = cfg.fast_rate;
        end else if (peak_above && gap > cfg.big_gap) begin
            rate = cfg.medium_rate;
        end else begin
            rate = cfg.slow_rate;
        end
    end

    // clamp of the stepped level
    always_comb begin
        down_lvl = step_reg[W-1:0];
        if (down_lvl < peak_reg) begin
            down_lvl = peak_reg;
        end
        if (down_lvl < cfg.silence_floor) begin
            down_lvl = cfg.silence_floor;
        end
        if (up_reg) begin
            level_next = (step_reg < {1'b0, peak_reg}) ? step_reg[W-1:0] : peak_reg;
        end else begin
            level_next = down_lvl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            level_reg   <= aln_pkg::RST_LEVEL;
            peak_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == aln_pkg::FUNC_MAG) begin
                            mag_reg   <= in_mag;
                            state_reg <= ST_MUL;
                        end else begin
                            if (in_rms > peak_reg) begin
                                peak_reg <= in_rms;
                            end
                            norm_reg  <= '0;
                            state_reg <= in_period ? ST_RATE : ST_EMIT;
                        end
                    end
                end
                ST_RATE: begin
                    up_reg <= peak_above;
                    if (peak_above) begin
                        step_reg <= {1'b0, level_reg} + {1'b0, rate};
                    end else if (level_reg > rate) begin
                        step_reg <= {1'b0, level_reg - rate};
                    end else begin
                        step_reg <= '0;
                    end
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP: begin
                    level_reg <= level_next;
                    peak_reg  <= '0;
                    if (count_reg != aln_pkg::CNT_MAX) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_MUL: begin
                    prod_reg  <= mag_reg * cfg.target_level;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (sat) begin
                        norm_reg  <= '1;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        norm_reg  <= div_quot;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {level_reg, norm_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a word is in flight");

    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide phase");

    a_peak_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLAMP |=> peak_reg == '0)
        else $error("peak not cleared after level update");

    a_count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == aln_pkg::CNT_MAX |=> count_reg == aln_pkg::CNT_MAX)
        else $error("update count wrapped");

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the audio level normalizer word by word. A scoreboard class tracks
// level, held peak and warm-up count at the block's widths and predicts each
// result as input words are accepted. A directed opening covers silence,
// warm-up, big-gap and slow steps, clamping, saturation and zero level.
// Random phases follow over several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;
    import aln_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_GAP    = 24;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_WORDS  = 210;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [SAMPLE_W-1:0] normalized;
        logic [SAMPLE_W-1:0] level;
    } result_t;

    class normalizer_sb;
        cfg_t                regs;
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] peak;
        logic [CNT_W-1:0]    updates;
        result_t             due[$];
        int                  mismatches;

        function new();
            regs.silence_floor  = RST_SILENCE_FLOOR;
            regs.big_gap        = RST_BIG_GAP;
            regs.fast_rate      = RST_FAST_RATE;
            regs.medium_rate    = RST_MEDIUM_RATE;
            regs.slow_rate      = RST_SLOW_RATE;
            regs.warmup_updates = RST_WARMUP_UPDATES;
            regs.target_level   = RST_TARGET_LEVEL;
            level      = RST_LEVEL;
            peak       = '0;
            updates    = '0;
            mismatches = 0;
        endfunction

        function void write_reg(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_SILENCE_FLOOR:  regs.silence_floor  = data;
                REG_BIG_GAP:        regs.big_gap        = data;
                REG_FAST_RATE:      regs.fast_rate      = data;
                REG_MEDIUM_RATE:    regs.medium_rate    = data;
                REG_SLOW_RATE:      regs.slow_rate      = data;
                REG_WARMUP_UPDATES: regs.warmup_updates = data[CNT_W-1:0];
                REG_TARGET_LEVEL:   regs.target_level   = data;
                default: ;
            endcase
        endfunction

        function logic [SAMPLE_W-1:0] rate_step();
            if (peak < regs.silence_floor) return '0;
            if (updates < regs.warmup_updates) return regs.fast_rate;
            if (peak > level && (peak - level) > regs.big_gap) return regs.medium_rate;
            return regs.slow_rate;
        endfunction

        function void level_update();
            logic [SAMPLE_W-1:0] stride;
            logic [SAMPLE_W:0]   raised;
            logic [SAMPLE_W-1:0] lowered;
            stride = rate_step();
            if (peak > level) begin
                raised = level + stride;
                level  = (raised < peak) ? raised[SAMPLE_W-1:0] : peak;
            end else begin
                lowered = (level > stride) ? level - stride : '0;
                if (lowered < peak) lowered = peak;
                if (lowered < regs.silence_floor) lowered = regs.silence_floor;
                level = lowered;
            end
            if (updates != CNT_MAX) updates = updates + 1'b1;
            peak = '0;
        endfunction

        function logic [SAMPLE_W-1:0] scaled(input logic [SAMPLE_W-1:0] mag);
            logic [PROD_W-1:0] prod;
            logic [PROD_W-1:0] quot;
            if (level == '0) return '1;
            prod = mag * regs.target_level;
            quot = prod / level;
            return (quot[PROD_W-1:SAMPLE_W] != '0) ? '1 : quot[SAMPLE_W-1:0];
        endfunction

        function void note_word(input logic func, input logic [SAMPLE_W-1:0] rms,
                                input logic period, input logic [SAMPLE_W-1:0] mag);
            result_t r;
            if (func == FUNC_RMS) begin
                if (rms > peak) peak = rms;
                if (period) level_update();
                r.normalized = '0;
            end else begin
                r.normalized = scaled(mag);
            end
            r.level = level;
            due.push_back(r);
        endfunction

        function void check_word(input logic [M_TDATA_W-1:0] word);
            result_t e;
            if (due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, word);
                mismatches++;
                return;
            end
            e = due.pop_front();
            if (word[SAMPLE_W-1:0] !== e.normalized) begin
                $display("%0t: normalized mismatch, expected %0d, got %0d",
                         $time, e.normalized, word[SAMPLE_W-1:0]);
                mismatches++;
            end
            if (word[2*SAMPLE_W-1:SAMPLE_W] !== e.level) begin
                $display("%0t: level mismatch, expected %0d, got %0d",
                         $time, e.level, word[2*SAMPLE_W-1:SAMPLE_W]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    normalizer_sb sb = new();

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_request = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    audio_level_normalizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side: check, then pick next tready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata);
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
            $display("[audio_level_normalizer] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    task automatic send_word(input logic func, input logic [SAMPLE_W-1:0] rms,
                             input logic period, input logic [SAMPLE_W-1:0] mag);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= S_TDATA_W'({mag, period, rms});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(func, rms, period, mag);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(addr, data);
    endtask

    task automatic wait_results();
        while (sb.due.size() != 0) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_results();
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(REG_SILENCE_FLOOR, c.silence_floor);
        write_reg(REG_BIG_GAP, c.big_gap);
        write_reg(REG_FAST_RATE, c.fast_rate);
        write_reg(REG_MEDIUM_RATE, c.medium_rate);
        write_reg(REG_SLOW_RATE, c.slow_rate);
        write_reg(REG_WARMUP_UPDATES, {12'($urandom), c.warmup_updates});
        write_reg(REG_TARGET_LEVEL, c.target_level);
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t phase_config(input int p);
        cfg_t c;
        case (p)
            0: c = '{RST_SILENCE_FLOOR, RST_BIG_GAP, RST_FAST_RATE, RST_MEDIUM_RATE,
                     RST_SLOW_RATE, RST_WARMUP_UPDATES, RST_TARGET_LEVEL};
            1: c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 16'd1};
            2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 16'hFFFF};
            default: begin
                c.silence_floor  = ($urandom_range(3) == 0) ? 16'($urandom)
                                                            : 16'($urandom_range(12000));
                c.big_gap        = 16'($urandom);
                c.fast_rate      = 16'($urandom);
                c.medium_rate    = 16'($urandom_range(8000));
                c.slow_rate      = 16'($urandom_range(2000));
                c.warmup_updates = 4'($urandom);
                c.target_level   = 16'($urandom_range(65535, 1));
            end
        endcase
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_rms();
        int v;
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(8191));
            2: begin
                v = int'(sb.level) + int'($urandom_range(4000)) - 2000;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
            default: return $urandom_range(1) ? 16'hFFFF : sb.regs.silence_floor;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_mag();
        case ($urandom_range(3))
            0: return 16'($urandom_range(255));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // a run of magnitudes, or a run of rms words mostly closed by a period update
    task automatic rand_burst(output int n);
        n = $urandom_range(6, 1);
        if ($urandom_range(99) < 45) begin
            repeat (n) send_word(FUNC_MAG, 16'($urandom), 1'($urandom), pick_mag());
        end else begin
            for (int i = 0; i < n; i++)
                send_word(FUNC_RMS, pick_rms(),
                          (i == n - 1) ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0),
                          16'($urandom));
        end
    endtask

    initial begin
        int  count;
        int  n;
        bit  paused;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= FUNC_RMS;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_addr  <= REG_SILENCE_FLOOR;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: zero, max and unit magnitudes, silence and warm-up steps
        set_idling(0);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'h0000);
        send_word(FUNC_MAG, 16'hFFFF, 1'b1, 16'hFFFF);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'h0001);
        send_word(FUNC_RMS, 16'd100, 1'b1, 16'h0000);
        send_word(FUNC_RMS, 16'hFFFF, 1'b0, 16'hFFFF);
        send_word(FUNC_RMS, 16'd5, 1'b1, 16'h0000);
        send_word(FUNC_RMS, 16'd20000, 1'b1, 16'h0000);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'hFFFF);
        settle();

        // no warm-up: big gap, small gap, peak equal to level, step down
        write_reg(REG_WARMUP_UPDATES, 16'h0000);
        cfg_valid <= 1'b0;
        send_word(FUNC_RMS, 16'hFFFF, 1'b1, 16'h0000);
        send_word(FUNC_RMS, sb.level + 16'd10, 1'b1, 16'h0000);
        send_word(FUNC_RMS, sb.level, 1'b1, 16'h0000);
        send_word(FUNC_RMS, 16'd6000, 1'b1, 16'h0000);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'd40000);
        settle();

        // zero floor and full fast step drive the level to zero
        write_reg(REG_SILENCE_FLOOR, 16'h0000);
        write_reg(REG_FAST_RATE, 16'hFFFF);
        write_reg(REG_WARMUP_UPDATES, 16'h000F);
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_word(FUNC_RMS, 16'h0000, 1'b1, 16'h0000);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'h1234);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'h0000);
        send_word(FUNC_RMS, 16'hFFFF, 1'b1, 16'h0000);
        send_word(FUNC_MAG, 16'h0000, 1'b0, 16'hFFFF);
        send_word(FUNC_RMS, 16'h0000, 1'b1, 16'h0000);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            load_config(phase_config(p));
            set_idling(p % 4);
            if (p == 0) hold_request <= 1'b1;
            count  = 0;
            paused = 1'b0;
            while (count < PHASE_WORDS) begin
                rand_burst(n);
                count += n;
                if (!paused && count >= PHASE_WORDS / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    wait_results();
                    paused = 1'b1;
                end
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.due.size() == 0) begin
            $display("[audio_level_normalizer] OK");
        end else begin
            $display("[audio_level_normalizer] ERROR");
        end
        $finish;
    end

endmodule

// File: audio_level_normalizer.f
rtl/aln_pkg.sv
rtl/aln_cfg_regs.sv
rtl/aln_div.sv
rtl/audio_level_normalizer.sv
tb/sv/testbench.sv
